/* rtl/cfd_pkg.sv */
// types, codes and the crc byte update shared by the frame decoder modules
package cfd_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_TOP = 16'h8000;
	localparam logic [7:0] OP_LOW_MASK = 8'h7F;
	localparam logic [7:0] RESPONSE_BIT = 8'h80;

	localparam logic [1:0] REG_START_OF_FRAME = 2'd0;
	localparam logic [1:0] REG_ERROR_OPCODE = 2'd1;
	localparam logic [1:0] REG_EVENT_OPCODE = 2'd2;

	localparam logic [2:0] STATUS_OK = 3'd0;
	localparam logic [2:0] STATUS_SHORT = 3'd1;
	localparam logic [2:0] STATUS_BAD_SOF = 3'd2;
	localparam logic [2:0] STATUS_SIZE = 3'd3;
	localparam logic [2:0] STATUS_CRC = 3'd4;
	localparam logic [2:0] STATUS_ERR_LEN = 3'd5;
	localparam logic [2:0] STATUS_EMPTY_EVENT = 3'd6;
	localparam logic [2:0] STATUS_NO_RESP_BIT = 3'd7;

	localparam logic [1:0] FTYPE_RESPONSE = 2'd0;
	localparam logic [1:0] FTYPE_EVENT = 2'd1;
	localparam logic [1:0] FTYPE_ERROR = 2'd2;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [1:0]  frame_type;
		logic [7:0]  frame_seq;
		logic [7:0]  req_op;
		logic [7:0]  evt_code;
		logic [7:0]  error_seq;
		logic [7:0]  err_code;
		logic [15:0] payload_length;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/cfd_out_skid.sv */
// output register with skid stage for decoder results
module cfd_out_skid
	import cfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    take;

	assign take = out_valid_q & ~out_stall;
	assign full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || take) begin
			out_data_q <= push_data;
		end else begin
			skid_data_q <= push_data;
		end
	end

endmodule

/* rtl/crc_checked_frame_decoder_core.sv */
// top level of the crc checked frame decoder
// Decodes SOF / length framed packets protected by CRC-16/CCITT-FALSE, one byte per
// transaction on the input channel; the byte with last high ends the frame. One byte
// is taken every clock cycle: the header capture, the unrolled 8-bit CRC update and
// the verdict checks all settle in the single cycle in which the byte is accepted,
// and the result goes to an output register backed by a one-entry skid stage, so the
// input only stalls while both of those hold results the consumer has not taken.
// Payload bytes and the end-of-frame verdict pass the output register, or the skid
// stage first when the consumer stalls. Event code and error-frame fields are held
// back and reported in the verdict. Configuration writes are meant for idle periods.
module crc_checked_frame_decoder_core
	import cfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic [1:0]  frame_type,
	output logic [7:0]  frame_seq,
	output logic [7:0]  req_op,
	output logic [7:0]  evt_code,
	output logic [7:0]  error_seq,
	output logic [7:0]  err_code,
	output logic [15:0] payload_length
);

	localparam logic [16:0] COUNT_MAX = '1;

	logic [7:0]  sof_cfg_q;
	logic [7:0]  err_op_cfg_q;
	logic [7:0]  evt_op_cfg_q;

	logic [16:0] byte_count_q;
	logic [15:0] crc_q;
	logic [7:0]  held_q;
	logic [7:0]  seq_q;
	logic [7:0]  op_q;
	logic [15:0] len_q;
	logic        sof_ok_q;
	logic [7:0]  cap_q [3];

	logic        accept;
	logic [16:0] p;
	logic [7:0]  seq_n;
	logic [7:0]  op_n;
	logic [15:0] len_n;
	logic        sof_n;
	logic        is_err;
	logic        is_evt;
	logic [16:0] crc_limit;
	logic [15:0] crc_n;
	logic        in_payload;
	logic [16:0] idx;
	logic        emit;
	logic [7:0]  cap_n [3];
	logic [16:0] size;
	logic [15:0] got_crc;
	logic [2:0]  status_n;
	logic        skid_full;
	logic        push;
	result_t     res;
	result_t     out_res;

	assign accept = in_valid & ~in_stall;
	assign in_stall = skid_full;
	assign p = byte_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_cfg_q <= 8'h00;
			err_op_cfg_q <= 8'h00;
			evt_op_cfg_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_OF_FRAME: sof_cfg_q <= cfg_data;
				REG_ERROR_OPCODE:   err_op_cfg_q <= cfg_data;
				REG_EVENT_OPCODE:   evt_op_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		seq_n = (p == 17'd1) ? data : seq_q;
		op_n = (p == 17'd2) ? data : op_q;
		sof_n = (p == 17'd0) ? (data == sof_cfg_q) : sof_ok_q;
		if (p == 17'd3) begin
			len_n = {data, 8'h00};
		end else if (p == 17'd4) begin
			len_n = {len_q[15:8], data};
		end else begin
			len_n = len_q;
		end

		is_err = (op_q == err_op_cfg_q);
		is_evt = !is_err && (op_q == evt_op_cfg_q);

		crc_limit = 17'd5 + {1'b0, len_n};
		crc_n = (p < crc_limit) ? crc16_byte(crc_q, data) : crc_q;

		idx = p - 17'd5;
		in_payload = (p >= 17'd5) && (idx < {1'b0, len_n});
		cap_n = cap_q;
		emit = 1'b0;
		if (in_payload) begin
			if (is_err && idx < 17'd3) begin
				cap_n[idx[1:0]] = data;
			end else if (is_evt && idx == 17'd0) begin
				cap_n[0] = data;
			end else begin
				emit = 1'b1;
			end
		end

		size = (p != COUNT_MAX) ? p + 17'd1 : COUNT_MAX;
		got_crc = {held_q, data};
		if (size < 17'd7) begin
			status_n = STATUS_SHORT;
		end else if (!sof_n) begin
			status_n = STATUS_BAD_SOF;
		end else if (size != 17'd7 + {1'b0, len_n}) begin
			status_n = STATUS_SIZE;
		end else if (crc_n != got_crc) begin
			status_n = STATUS_CRC;
		end else if (is_err && len_n != 16'd3) begin
			status_n = STATUS_ERR_LEN;
		end else if (is_evt && len_n == 16'd0) begin
			status_n = STATUS_EMPTY_EVENT;
		end else if (!is_err && !is_evt && (op_n & RESPONSE_BIT) == 8'h00) begin
			status_n = STATUS_NO_RESP_BIT;
		end else begin
			status_n = STATUS_OK;
		end

		res = '0;
		if (last) begin
			res.result_kind = KIND_VERDICT;
			res.status = status_n;
			res.frame_seq = seq_n;
			res.payload_length = len_n;
			if (is_err) begin
				res.frame_type = FTYPE_ERROR;
				res.req_op = cap_n[1];
				res.error_seq = cap_n[0];
				res.err_code = cap_n[2];
			end else if (is_evt) begin
				res.frame_type = FTYPE_EVENT;
				res.evt_code = cap_n[0];
			end else begin
				res.frame_type = FTYPE_RESPONSE;
				res.req_op = op_n & OP_LOW_MASK;
			end
		end else begin
			res.result_kind = KIND_PAYLOAD;
			res.payload_byte = data;
		end
	end

	assign push = accept & (last | emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q <= CRC_INIT;
			held_q <= 8'h00;
			seq_q <= 8'h00;
			op_q <= 8'h00;
			len_q <= 16'h0000;
			sof_ok_q <= 1'b0;
			cap_q <= '{default: 8'h00};
		end else if (accept) begin
			if (last) begin
				byte_count_q <= '0;
				crc_q <= CRC_INIT;
				held_q <= 8'h00;
				seq_q <= 8'h00;
				op_q <= 8'h00;
				len_q <= 16'h0000;
				sof_ok_q <= 1'b0;
				cap_q <= '{default: 8'h00};
			end else begin
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + 17'd1;
				end
				crc_q <= crc_n;
				held_q <= data;
				seq_q <= seq_n;
				op_q <= op_n;
				len_q <= len_n;
				sof_ok_q <= sof_n;
				cap_q <= cap_n;
			end
		end
	end

	cfd_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign result_kind = out_res.result_kind;
	assign payload_byte = out_res.payload_byte;
	assign status = out_res.status;
	assign frame_type = out_res.frame_type;
	assign frame_seq = out_res.frame_seq;
	assign req_op = out_res.req_op;
	assign evt_code = out_res.evt_code;
	assign error_seq = out_res.error_seq;
	assign err_code = out_res.err_code;
	assign payload_length = out_res.payload_length;

endmodule
